// File: hdl/mpbf_pkg.sv
// Shared types and constants for the min-plus Bellman-Ford block.
// No dependencies.
package mpbf_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ROUNDS = 2'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RUN   = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWEEP = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_UPDT  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Control from the sequencer to the cell chain.
    typedef struct packed {
        logic init;     // load initial distances
        logic shift;    // rotate distance ring one place
        logic commit;   // fold relaxed value into each cell
    } cell_ctrl_t;

endpackage

// File: hdl/minplus_bellman_ford.sv
// Top level: matrix memory, distance cell ring, round sequencer, output.
// Depends on mpbf_pkg and mpbf_cell.
//
// channel | ports                      | role
// s_      | action..edge_missing       | matrix write or run beat
// m_      | node_index..last           | one distance beat per node
// cfg_    | index, data                | register writes
//
// A run sweeps the N*N matrix R times, then gives N output beats,
// N = active node count, R = rounds; the single matrix read port
// (one entry a cycle) paces each sweep. During a run each
// row v is swept over u while the distance ring rotates past the adder.
// Reset clears control and sets the config registers to their defaults; distances are set by a run.
// m_ready low holds the output register; s_ready is low during a run.
module minplus_bellman_ford #(
    parameter int NODES       = 64,
    parameter int WEIGHT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [5:0]  s_row_index,
    input  logic [5:0]  s_col_index,
    input  logic signed [31:0] s_edge_weight,
    input  logic        s_edge_missing,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_node_index,
    output logic signed [31:0] m_distance,
    output logic        m_unreachable,
    output logic [9:0]  m_rounds_used,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mpbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import mpbf_pkg::*;

    localparam int WB  = WEIGHT_BITS;
    localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NCW = $clog2(NODES + 1);
    localparam int AW  = 2 * NW;
    localparam logic signed [WB-1:0] WMAX = {1'b0, {(WB-1){1'b1}}};
    localparam logic signed [WB-1:0] WMIN = {1'b1, {(WB-1){1'b0}}};

    // ---------------- configuration registers
    logic [6:0] node_count_reg;
    logic [5:0] source_node_reg;
    logic [9:0] round_count_reg;
    logic       default_rounds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg     <= 7'd64;
            source_node_reg    <= 6'd0;
            round_count_reg    <= 10'd63;
            default_rounds_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NODE_COUNT:     node_count_reg     <= cfg_data[6:0];
                REG_SOURCE_NODE:    source_node_reg    <= cfg_data[5:0];
                REG_ROUND_COUNT:    round_count_reg    <= cfg_data[9:0];
                REG_DEFAULT_ROUNDS: default_rounds_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective node count 1..NODES and round count
    logic [NCW-1:0] cnt;
    logic [9:0]     rounds;
    always_comb begin
        if (node_count_reg == 7'd0)
            cnt = NCW'(1);
        else if ({25'd0, node_count_reg} > NODES)
            cnt = NCW'(NODES);
        else
            cnt = NCW'(node_count_reg);
        rounds = default_rounds_reg ? 10'(cnt - NCW'(1)) : round_count_reg;
    end

    // ---------------- sequencer state
    state_t          st_reg, st_next;
    logic [NW-1:0]   row_reg, col_reg;  // v and u of the sweep
    logic [9:0]      rnd_reg;
    logic [9:0]      rounds_reg;
    logic [NCW-1:0]  cnt_reg;
    logic [NCW-1:0]  step_reg;          // drain counter
    logic            out_ld;

    // ---------------- adjacency memory
    logic [WB:0]     adj_mem [NODES*NODES];
    logic [WB:0]     adj_rd_reg;
    logic            wr_en;
    logic signed [WB-1:0] w_sat;
    logic            s_acc;

    assign s_ready = (st_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign wr_en   = s_acc && s_action == ACT_WRITE
                     && {26'd0, s_row_index} < NODES && {26'd0, s_col_index} < NODES;

    // saturate incoming weight into WB bits
    always_comb begin
        logic signed [63:0] wx;
        wx = 64'(s_edge_weight);
        if (wx > 64'(WMAX))      w_sat = WMAX;
        else if (wx < 64'(WMIN)) w_sat = WMIN;
        else                     w_sat = WB'(wx);
        if (s_edge_missing) w_sat = '0;
    end

    logic [AW-1:0] wr_addr, rd_addr;
    assign wr_addr = {s_row_index[NW-1:0], s_col_index[NW-1:0]};
    assign rd_addr = {row_reg, col_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) adj_mem[wr_addr] <= {s_edge_missing, w_sat};
        adj_rd_reg <= adj_mem[rd_addr];
    end

    // ---------------- cell ring
    // Cell k holds dist[(k + shift) mod cnt]; cell 0 feeds the adder.
    // The ring is NODES long; shorter graphs close at cell cnt-1.
    cell_ctrl_t       ctrl;
    logic [NODES-1:0] c_inf;
    logic signed [WB-1:0] c_val [NODES];
    logic [NODES-1:0] c_init;

    // relaxed store, one register per node
    logic [NODES-1:0]     rl_inf_reg;
    logic signed [WB-1:0] rl_val_reg [NODES];

    for (genvar k = 0; k < NODES; k++) begin : g_cell
        logic                 p_inf;
        logic signed [WB-1:0] p_val;
        // ring closure: last active cell takes cell 0
        assign p_inf = (k == NODES-1 || NCW'(k + 1) == cnt_reg) ? c_inf[0]
                       : c_inf[(k+1) % NODES];
        assign p_val = (k == NODES-1 || NCW'(k + 1) == cnt_reg) ? c_val[0]
                       : c_val[(k+1) % NODES];
        assign c_init[k] = !(NW'(k) == source_node_reg[NW-1:0]
                             && {26'd0, source_node_reg} < cnt
                             && {26'd0, source_node_reg} < NODES);
        mpbf_cell #(.WB(WB)) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .init_inf (c_init[k]),
            .prev_inf (p_inf),
            .prev_val (p_val),
            .rlx_inf  (rl_inf_reg[k]),
            .rlx_val  (rl_val_reg[k]),
            .dist_inf (c_inf[k]),
            .dist_val (c_val[k])
        );
    end

    // ---------------- adder / min accumulator
    // pipeline: address from row/col, then registered memory data aligned with the registered ring head
    logic                 dh_inf_reg;    // ring head, registered to align with memory data
    logic signed [WB-1:0] dh_val_reg;
    logic                 acc_vld_reg, acc_vld2_reg, acc_last_reg, acc_last2_reg;
    logic [NW-1:0]        acc_row_reg, acc_row2_reg;
    logic                 s_inf_reg;
    logic signed [WB-1:0] s_val_reg;
    logic                 best_inf_reg;
    logic signed [WB-1:0] best_val_reg;
    logic                 sum_inf;
    logic signed [WB-1:0] sum_val;
    logic signed [WB:0]   sum_wide;
    logic                 take;
    logic                 best_clr;

    always_comb begin
        sum_inf  = adj_rd_reg[WB] || dh_inf_reg;
        sum_wide = (WB+1)'(signed'(adj_rd_reg[WB-1:0])) + (WB+1)'(dh_val_reg);
        if (sum_wide[WB] != sum_wide[WB-1])
            sum_val = sum_wide[WB] ? WMIN : WMAX;
        else
            sum_val = sum_wide[WB-1:0];
    end

    // new sum beats the running minimum; restart at idle and after a row
    assign take     = acc_vld2_reg && !s_inf_reg
                      && (best_inf_reg || s_val_reg < best_val_reg);
    assign best_clr = (st_reg == ST_IDLE) || (acc_vld2_reg && acc_last2_reg);

    always_ff @(posedge aclk) begin
        dh_inf_reg    <= c_inf[0];
        dh_val_reg    <= c_val[0];
        acc_vld2_reg  <= acc_vld_reg;
        acc_last2_reg <= acc_last_reg;
        acc_row2_reg  <= acc_row_reg;
        s_inf_reg     <= sum_inf;
        s_val_reg     <= sum_val;
        // stage 3: running minimum, written to relaxed at row end
        if (best_clr) begin
            best_inf_reg <= 1'b1;
            best_val_reg <= '0;
        end else if (take) begin
            best_inf_reg <= 1'b0;
            best_val_reg <= s_val_reg;
        end
        if (acc_vld2_reg && acc_last2_reg) begin
            rl_inf_reg[acc_row2_reg] <= take ? 1'b0 : best_inf_reg;
            rl_val_reg[acc_row2_reg] <= take ? s_val_reg : best_val_reg;
        end
    end

    // ---------------- sequencer
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (s_acc && s_action == ACT_RUN)
                          st_next = (rounds == 10'd0) ? ST_OUT : ST_SWEEP;
            ST_SWEEP: if (row_reg == NW'(cnt_reg - NCW'(1))
                          && col_reg == NW'(cnt_reg - NCW'(1)))
                          st_next = ST_DRAIN;
            ST_DRAIN: if (step_reg == NCW'(3)) st_next = ST_UPDT;
            ST_UPDT:  st_next = (rnd_reg + 10'd1 == rounds_reg) ? ST_OUT : ST_SWEEP;
            ST_OUT:   if (out_ld && NCW'(row_reg) == cnt_reg - NCW'(1)
                          && !(m_valid && !m_ready))
                          st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // sweep order: row v, then u = 0..cnt-1; ring shifts each u step
    always_comb begin
        ctrl.init   = (st_reg == ST_IDLE) && s_acc && s_action == ACT_RUN;
        ctrl.shift  = (st_reg == ST_SWEEP) || (st_reg == ST_OUT && out_ld);
        ctrl.commit = (st_reg == ST_UPDT);
    end

    // output register load: ring head is node row_reg
    assign out_ld = (st_reg == ST_OUT) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            m_valid      <= 1'b0;
            acc_vld_reg  <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            rnd_reg      <= '0;
            step_reg     <= '0;
            cnt_reg      <= NCW'(1);
            rounds_reg   <= '0;
            acc_last_reg <= 1'b0;
            acc_row_reg  <= '0;
        end else begin
            st_reg       <= st_next;
            acc_vld_reg  <= (st_reg == ST_SWEEP);
            acc_last_reg <= (st_reg == ST_SWEEP) && NCW'(col_reg) == cnt_reg - NCW'(1);
            acc_row_reg  <= row_reg;
            if (out_ld)       m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    cnt_reg    <= cnt;
                    rounds_reg <= rounds;
                    row_reg    <= '0;
                    col_reg    <= '0;
                    rnd_reg    <= '0;
                    step_reg   <= '0;
                end
                ST_SWEEP: begin
                    if (NCW'(col_reg) == cnt_reg - NCW'(1)) begin
                        col_reg <= '0;
                        row_reg <= row_reg + NW'(1);
                    end else begin
                        col_reg <= col_reg + NW'(1);
                    end
                    step_reg <= '0;
                end
                ST_DRAIN: step_reg <= step_reg + NCW'(1);
                ST_UPDT: begin
                    rnd_reg <= rnd_reg + 10'd1;
                    row_reg <= '0;
                    col_reg <= '0;
                end
                ST_OUT: begin
                    if (out_ld) begin
                        m_node_index  <= 6'(row_reg);
                        m_unreachable <= c_inf[0];
                        m_distance    <= c_inf[0] ? 32'sd0 : 32'(c_val[0]);
                        m_rounds_used <= rounds_reg;
                        m_last        <= NCW'(row_reg) == cnt_reg - NCW'(1);
                        row_reg       <= row_reg + NW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: hdl/mpbf_cell.sv
// One cell of the distance ring: holds dist[u] and folds in the relaxed value on commit.
// Depends on mpbf_pkg.
module mpbf_cell #(
    parameter int WB = 32
) (
    input  logic                  aclk,
    input  mpbf_pkg::cell_ctrl_t  ctrl,
    input  logic                  init_inf,
    input  logic                  prev_inf,
    input  logic signed [WB-1:0]  prev_val,
    input  logic                  rlx_inf,
    input  logic signed [WB-1:0]  rlx_val,
    output logic                  dist_inf,
    output logic signed [WB-1:0]  dist_val
);
    import mpbf_pkg::*;

    logic              inf_reg;
    logic signed [WB-1:0] val_reg;
    logic              less;

    assign less = !rlx_inf && (inf_reg || rlx_val < val_reg);

    // ring shift, init, or commit of min(dist, relaxed)
    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            inf_reg <= init_inf;
            val_reg <= '0;
        end else if (ctrl.shift) begin
            inf_reg <= prev_inf;
            val_reg <= prev_val;
        end else if (ctrl.commit && less) begin
            inf_reg <= 1'b0;
            val_reg <= rlx_val;
        end
    end

    assign dist_inf = inf_reg;
    assign dist_val = val_reg;
endmodule
